// ===== rtl/core/lmsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lmsd_pkg
// Types and constants shared by the LED matrix scan driver.
// ----------------------------------------------------------------------------
package lmsd_pkg;

   localparam int BUFFER_BYTES = 24;
   localparam int BANK_BYTES   = 8;
   localparam int BANKS        = BUFFER_BYTES / BANK_BYTES;
   localparam int SCAN_LINES   = 8;

   localparam logic [3:0] COL_LAST_STEP = 4'd3;
   localparam logic [3:0] ROW_LAST_STEP = 4'd12;
   localparam logic [3:0] ROW_SEL_STEP  = 4'd9;
   localparam logic [3:0] ROW_GATHER_LAST = 4'd8;

   localparam logic       LAYOUT_RESET    = 1'b0;
   localparam logic       DRIVER_RESET    = 1'b1;
   localparam logic [7:0] FRAME_DELAY_RESET = 8'd100;
   localparam logic [7:0] DIM_STEP_RESET  = 8'd4;
   localparam logic [7:0] DIM_LIMIT_RESET = 8'd25;
   localparam logic [7:0] BOUNDARY_RESET  = 8'd3;
   localparam logic [7:0] TIMER_DIV_RESET = 8'd33;

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_LIGHT = 2'd1,
      FUNC_WRITE = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      REG_LAYOUT    = 3'd0,
      REG_DRIVER    = 3'd1,
      REG_FRAME     = 3'd2,
      REG_DIM_STEP  = 3'd3,
      REG_DIM_LIMIT = 3'd4,
      REG_BOUNDARY  = 3'd5,
      REG_TIMER_DIV = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [1:0] func;
      logic [4:0] buffer_index;
      logic [7:0] pixel_byte;
      logic [7:0] light_level;
      logic       clock_mode_active;
   } req_word_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] shift_byte;
      logic       latch_pulse;
      logic       display_on;
      logic       timer_tick;
   } rsp_word_type;

endpackage

// ===== rtl/core/lmsd_ram.sv =====
// ----------------------------------------------------------------------------
// lmsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== rtl/core/led_matrix_scan_with_dimming.sv =====
// ----------------------------------------------------------------------------
// led_matrix_scan_with_dimming
// Multiplexed LED matrix scan driver with ambient-light dimming.
// A result word is registered in the output stage before it appears on rsp_*.
// One word per cycle while req_stall is low; the frame buffer banks are read
// ahead from the next scan position, so no tick waits on the memory port.
// A two-word output stage takes one more request while a result is stalled.
// Reset (synchronous) restores registers and scan state; frame buffer
// entries read as zero until written, through per-entry valid bits.
// ----------------------------------------------------------------------------
module led_matrix_scan_with_dimming
   import lmsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [4:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   // configuration
   logic       layout_ff, driver_ff;
   logic [7:0] frame_delay_ff, dim_step_ff, dim_limit_ff, boundary_ff, timer_div_ff;
   logic       cfg_we;
   logic [2:0] cfg_idx;
   logic       layout_in;

   // scan state
   logic [7:0] cd_ff, cd_in;
   logic [3:0] step_ff, step_in;
   logic [2:0] line_ff, line_in;
   logic [7:0] rows_ff [BANKS];
   logic [7:0] rows_in [BANKS];
   logic [7:0] div_ff, div_in;
   logic [7:0] dim_level_ff, dim_level_in;
   logic       enable_ff, enable_in;

   // frame buffer
   logic [7:0] ent_valid_ff [BANKS];
   logic [2:0] rd_addr_ff, rd_addr_in;
   logic [BANKS-1:0] bank_we;
   logic [BANKS-1:0] fwd_hit_ff, fwd_hit_in;
   logic [7:0] fwd_data_ff;
   logic [7:0] ram_q [BANKS];
   logic [7:0] bank_word [BANKS];
   logic       wr_ok;

   // handshake and output stage
   logic         acc, pop;
   logic         main_valid_ff, main_valid_in, skid_valid_ff, skid_valid_in;
   rsp_word_type main_word_ff, main_word_in, skid_word_ff, skid_word_in;
   rsp_word_type res;

   // step helpers
   logic       tick;
   logic       next_line;
   logic [3:0] last_step;
   logic [2:0] line_inc;
   logic [7:0] sel;
   logic [15:0] prod;
   logic [7:0] fine_off;

   assign acc       = req_valid && !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign pop       = main_valid_ff && !rsp_stall;
   assign rsp_valid = main_valid_ff;
   assign rsp_word  = main_word_ff;

   // ---------------- configuration port ----------------
   assign pready  = 1'b1;
   assign cfg_we  = psel && penable && pwrite;
   assign cfg_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff      <= LAYOUT_RESET;
         driver_ff      <= DRIVER_RESET;
         frame_delay_ff <= FRAME_DELAY_RESET;
         dim_step_ff    <= DIM_STEP_RESET;
         dim_limit_ff   <= DIM_LIMIT_RESET;
         boundary_ff    <= BOUNDARY_RESET;
         timer_div_ff   <= TIMER_DIV_RESET;
      end else if (cfg_we) begin
         case (cfg_idx)
            REG_LAYOUT:    layout_ff      <= pwdata[0];
            REG_DRIVER:    driver_ff      <= pwdata[0];
            REG_FRAME:     frame_delay_ff <= pwdata[7:0];
            REG_DIM_STEP:  dim_step_ff    <= pwdata[7:0];
            REG_DIM_LIMIT: dim_limit_ff   <= pwdata[7:0];
            REG_BOUNDARY:  boundary_ff    <= pwdata[7:0];
            REG_TIMER_DIV: timer_div_ff   <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         REG_LAYOUT:    prdata = {31'd0, layout_ff};
         REG_DRIVER:    prdata = {31'd0, driver_ff};
         REG_FRAME:     prdata = {24'd0, frame_delay_ff};
         REG_DIM_STEP:  prdata = {24'd0, dim_step_ff};
         REG_DIM_LIMIT: prdata = {24'd0, dim_limit_ff};
         REG_BOUNDARY:  prdata = {24'd0, boundary_ff};
         REG_TIMER_DIV: prdata = {24'd0, timer_div_ff};
         default:       prdata = 32'd0;
      endcase
   end

   assign layout_in = (cfg_we && cfg_idx == REG_LAYOUT) ? pwdata[0] : layout_ff;

   // ---------------- frame buffer banks ----------------
   // bank k holds bytes 8k..8k+7; a column reads entry 7-line of every bank,
   // a row gather reads entry step-1 of every bank
   assign wr_ok = acc && (req_word.func == FUNC_WRITE) &&
                  (req_word.buffer_index[4:3] != 2'd3);

   always_comb begin
      if (reset) begin
         rd_addr_in = 3'd7;
      end else if (layout_in) begin
         rd_addr_in = 3'(step_in - 4'd1);
      end else begin
         rd_addr_in = ~line_in;
      end
   end

   for (genvar k = 0; k < BANKS; k++) begin : g_bank
      assign bank_we[k]    = wr_ok && (req_word.buffer_index[4:3] == 2'(k));
      assign fwd_hit_in[k] = bank_we[k] && (req_word.buffer_index[2:0] == rd_addr_in);

      lmsd_ram #(
         .WIDTH (8),
         .DEPTH (BANK_BYTES)
      ) u_ram (
         .clock (clock),
         .we    (bank_we[k]),
         .waddr (req_word.buffer_index[2:0]),
         .wdata (req_word.pixel_byte),
         .raddr (rd_addr_in),
         .rdata (ram_q[k])
      );

      // forward a write that hit the entry being read, zero for unwritten
      assign bank_word[k] = fwd_hit_ff[k] ? fwd_data_ff :
                            (ent_valid_ff[k][rd_addr_ff] ? ram_q[k] : 8'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < BANKS; k++) begin
            ent_valid_ff[k] <= 8'd0;
         end
         fwd_hit_ff <= '0;
      end else begin
         if (wr_ok) begin
            ent_valid_ff[req_word.buffer_index[4:3]][req_word.buffer_index[2:0]] <= 1'b1;
         end
         fwd_hit_ff <= fwd_hit_in;
      end
      rd_addr_ff  <= rd_addr_in;
      fwd_data_ff <= req_word.pixel_byte;
   end

   // ---------------- item processing ----------------
   assign sel      = 8'd1 << line_ff;
   assign line_inc = line_ff + 3'd1;
   assign prod     = req_word.light_level * dim_step_ff;
   assign fine_off = layout_ff ? 8'(ROW_LAST_STEP + 4'd3) : 8'(COL_LAST_STEP + 4'd3);

   always_comb begin
      cd_in        = cd_ff;
      step_in      = step_ff;
      line_in      = line_ff;
      div_in       = div_ff;
      dim_level_in = dim_level_ff;
      enable_in    = enable_ff;
      for (int k = 0; k < BANKS; k++) begin
         rows_in[k] = rows_ff[k];
      end
      res       = '0;
      tick      = 1'b0;
      next_line = 1'b0;
      last_step = COL_LAST_STEP;

      if (acc) begin
         case (req_word.func)
            FUNC_TICK: begin
               if (div_ff != 8'd0) begin
                  div_in = div_ff - 8'd1;
               end else begin
                  div_in = timer_div_ff;
                  tick   = 1'b1;
               end
               if (cd_ff != 8'd0) begin
                  cd_in     = cd_ff - 8'd1;
                  enable_in = (cd_in > dim_level_ff);
               end else if (layout_ff) begin
                  step_in   = step_ff + 4'd1;
                  last_step = ROW_LAST_STEP;
                  if (step_ff == 4'd0) begin
                     for (int k = 0; k < BANKS; k++) begin
                        rows_in[k] = 8'd0;
                     end
                  end else if (step_ff <= ROW_GATHER_LAST) begin
                     for (int k = 0; k < BANKS; k++) begin
                        rows_in[k] = {rows_ff[k][6:0], bank_word[k][line_ff]};
                     end
                  end else if (step_ff == ROW_SEL_STEP) begin
                     res.byte_valid = 1'b1;
                     res.shift_byte = sel;
                  end else if (step_ff <= ROW_LAST_STEP) begin
                     res.byte_valid = 1'b1;
                     case (step_ff)
                        4'd10:   res.shift_byte = rows_ff[0];
                        4'd11:   res.shift_byte = rows_ff[1];
                        default: res.shift_byte = rows_ff[2];
                     endcase
                     if (step_ff == ROW_LAST_STEP) begin
                        res.latch_pulse = 1'b1;
                        next_line       = 1'b1;
                     end
                  end
               end else begin
                  step_in = step_ff + 4'd1;
                  if (step_ff <= COL_LAST_STEP) begin
                     res.byte_valid = 1'b1;
                     case (step_ff[1:0])
                        2'd0:    res.shift_byte = driver_ff ? sel : bank_word[0];
                        2'd1:    res.shift_byte = driver_ff ? bank_word[0] : bank_word[1];
                        2'd2:    res.shift_byte = driver_ff ? bank_word[1] : bank_word[2];
                        default: res.shift_byte = driver_ff ? bank_word[2] : ~sel;
                     endcase
                     if (step_ff == COL_LAST_STEP) begin
                        res.latch_pulse = 1'b1;
                        next_line       = 1'b1;
                     end
                  end
               end
               if (next_line) begin
                  line_in = ({1'b0, line_inc} >= 4'(SCAN_LINES)) ? 3'd0 : line_inc;
                  cd_in   = frame_delay_ff - 8'(last_step);
                  step_in = 4'd0;
               end
            end
            FUNC_LIGHT: begin
               if (!req_word.clock_mode_active) begin
                  dim_level_in = 8'd0;
               end else if (req_word.light_level <= boundary_ff) begin
                  dim_level_in = frame_delay_ff - req_word.light_level - fine_off;
               end else if (req_word.light_level <= dim_limit_ff) begin
                  dim_level_in = frame_delay_ff - prod[7:0];
               end else begin
                  dim_level_in = 8'd0;
               end
            end
            default: ;
         endcase
      end
      res.display_on  = enable_in;
      res.timer_tick  = tick;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cd_ff        <= FRAME_DELAY_RESET;
         step_ff      <= 4'd0;
         line_ff      <= 3'd0;
         div_ff       <= TIMER_DIV_RESET;
         dim_level_ff <= 8'd0;
         enable_ff    <= 1'b1;
         for (int k = 0; k < BANKS; k++) begin
            rows_ff[k] <= 8'd0;
         end
      end else begin
         cd_ff        <= cd_in;
         step_ff      <= step_in;
         line_ff      <= line_in;
         div_ff       <= div_in;
         dim_level_ff <= dim_level_in;
         enable_ff    <= enable_in;
         for (int k = 0; k < BANKS; k++) begin
            rows_ff[k] <= rows_in[k];
         end
      end
   end

   // ---------------- output stage ----------------
   always_comb begin
      main_valid_in = main_valid_ff;
      main_word_in  = main_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_word_in  = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (acc) begin
         if (!main_valid_ff || pop) begin
            main_valid_in = 1'b1;
            main_word_in  = res;
         end else begin
            // hold the stalled word, park the new one
            skid_valid_in = 1'b1;
            skid_word_in  = res;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_word_ff <= main_word_in;
      skid_word_ff <= skid_word_in;
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED matrix scan driver. Each accepted request
// word runs through a mirror of the scan, dimming and timer logic held
// inside the bench. The output word that comes back is compared field by
// field in order. Register settings change between phases while the block
// is idle. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
   import lmsd_pkg::*;

   localparam logic [1:0] FUNC_NONE   = 2'd3;
   localparam int         PHASE_WORDS = 220;
   localparam int         ERROR_SHOWN = 40;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
   } stall_mode_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [4:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   led_matrix_scan_with_dimming u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // register copy
   logic       cfg_layout     = LAYOUT_RESET;
   logic       cfg_driver     = DRIVER_RESET;
   logic [7:0] cfg_frame      = FRAME_DELAY_RESET;
   logic [7:0] cfg_dim_step   = DIM_STEP_RESET;
   logic [7:0] cfg_dim_limit  = DIM_LIMIT_RESET;
   logic [7:0] cfg_boundary   = BOUNDARY_RESET;
   logic [7:0] cfg_timer_div  = TIMER_DIV_RESET;

   // scan state mirror
   logic [7:0] pixel_mirror [BUFFER_BYTES];
   logic [7:0] row_bits [BANKS];
   logic [7:0] dim_count  = FRAME_DELAY_RESET;
   logic [3:0] step_idx   = '0;
   logic [2:0] line_idx   = '0;
   logic [7:0] div_count  = TIMER_DIV_RESET;
   logic [7:0] dim_lvl    = '0;
   logic       display_en = 1'b1;

   req_word_type request_words [$];
   rsp_word_type pending_outputs [$];

   int errors;
   int func_count [4];
   int words_checked, bytes_seen, latches_seen, pulses_seen, dark_seen;
   int phases;

   initial begin
      foreach (pixel_mirror[i]) pixel_mirror[i] = '0;
      foreach (row_bits[i]) row_bits[i] = '0;
   end

   function automatic void finish_line(logic [3:0] last);
      line_idx  = line_idx + 3'd1;
      dim_count = cfg_frame - last;
      step_idx  = '0;
   endfunction

   function automatic rsp_word_type compute_scan_output(req_word_type w);
      rsp_word_type o;
      logic [7:0]   sel;
      logic [7:0]   seq [4];
      logic [3:0]   s;
      logic [3:0]   last;
      int           ln;
      o  = '0;
      ln = line_idx;
      s  = step_idx;
      case (w.func)
         FUNC_TICK: begin
            if (div_count != 0) begin
               div_count = div_count - 8'd1;
            end else begin
               div_count    = cfg_timer_div;
               o.timer_tick = 1'b1;
            end
            if (dim_count != 0) begin
               dim_count  = dim_count - 8'd1;
               display_en = (dim_count <= dim_lvl) ? 1'b0 : 1'b1;
            end else if (cfg_layout) begin
               if (s == 0) begin
                  foreach (row_bits[k]) row_bits[k] = '0;
               end else if (s <= ROW_GATHER_LAST) begin
                  foreach (row_bits[k])
                     row_bits[k] = {row_bits[k][6:0], pixel_mirror[s - 1 + BANK_BYTES * k][ln]};
               end else if (s == ROW_SEL_STEP) begin
                  o.byte_valid = 1'b1;
                  o.shift_byte = 8'd1 << ln;
               end else if (s <= ROW_LAST_STEP) begin
                  o.byte_valid = 1'b1;
                  o.shift_byte = row_bits[s - 10];
               end
               if (s == ROW_LAST_STEP) begin
                  o.latch_pulse = 1'b1;
                  finish_line(ROW_LAST_STEP);
               end else begin
                  step_idx = s + 4'd1;
               end
            end else begin
               sel = 8'd1 << ln;
               if (cfg_driver) begin
                  seq[0] = sel;
                  seq[1] = pixel_mirror[7 - ln];
                  seq[2] = pixel_mirror[15 - ln];
                  seq[3] = pixel_mirror[23 - ln];
               end else begin
                  seq[0] = pixel_mirror[7 - ln];
                  seq[1] = pixel_mirror[15 - ln];
                  seq[2] = pixel_mirror[23 - ln];
                  seq[3] = ~sel;
               end
               if (s > COL_LAST_STEP) begin
                  // leftover row step after a layout change: emit nothing
                  step_idx = s + 4'd1;
               end else begin
                  o.byte_valid = 1'b1;
                  o.shift_byte = seq[s[1:0]];
                  if (s == COL_LAST_STEP) begin
                     o.latch_pulse = 1'b1;
                     finish_line(COL_LAST_STEP);
                  end else begin
                     step_idx = s + 4'd1;
                  end
               end
            end
         end
         FUNC_LIGHT: begin
            last = cfg_layout ? ROW_LAST_STEP : COL_LAST_STEP;
            if (!w.clock_mode_active)
               dim_lvl = '0;
            else if (w.light_level <= cfg_boundary)
               dim_lvl = cfg_frame - w.light_level - (last + 3);
            else if (w.light_level <= cfg_dim_limit)
               dim_lvl = cfg_frame - w.light_level * cfg_dim_step;
            else
               dim_lvl = '0;
         end
         FUNC_WRITE: begin
            if (w.buffer_index < BUFFER_BYTES)
               pixel_mirror[w.buffer_index] = w.pixel_byte;
         end
         default: ;
      endcase
      o.display_on = display_en;
      return o;
   endfunction

   // sender: bursts of random length, random gaps between them
   int burst_left, gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_outputs.push_back(compute_scan_output(req_word));
            func_count[req_word.func]++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (request_words.size() != 0) begin
               req_word  <= request_words.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 48);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern
   stall_mode_type stall_mode;
   int             stall_hold, stall_phase;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_mode  <= STALL_NONE;
         stall_hold  <= 0;
         stall_phase <= 0;
      end else begin
         stall_phase <= stall_phase + 1;
         if (stall_hold == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
            stall_hold <= $urandom_range(30, 200);
         end else begin
            stall_hold <= stall_hold - 1;
         end
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: rsp_stall <= (stall_phase % 5) >= 3;
            default:        rsp_stall <= 1'b0;
         endcase
      end
   end

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= ERROR_SHOWN)
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_outputs.size() == 0) begin
            errors++;
            if (errors <= ERROR_SHOWN)
               $display("%0t ns: output word with nothing expected, actual %h", $time, rsp_word);
         end else begin
            want = pending_outputs.pop_front();
            check_field("byte_valid", 8'(want.byte_valid), 8'(rsp_word.byte_valid));
            check_field("shift_byte", want.shift_byte, rsp_word.shift_byte);
            check_field("latch_pulse", 8'(want.latch_pulse), 8'(rsp_word.latch_pulse));
            check_field("display_on", 8'(want.display_on), 8'(rsp_word.display_on));
            check_field("timer_tick", 8'(want.timer_tick), 8'(rsp_word.timer_tick));
            words_checked++;
            bytes_seen   += rsp_word.byte_valid;
            latches_seen += rsp_word.latch_pulse;
            pulses_seen  += rsp_word.timer_tick;
            dark_seen    += !rsp_word.display_on;
         end
      end
   end

   task automatic write_register(reg_index_type r, logic [7:0] value);
      logic [31:0] data;
      data      = $urandom;
      data[7:0] = value;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {r, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (r)
         REG_LAYOUT:    cfg_layout    = data[0];
         REG_DRIVER:    cfg_driver    = data[0];
         REG_FRAME:     cfg_frame     = data[7:0];
         REG_DIM_STEP:  cfg_dim_step  = data[7:0];
         REG_DIM_LIMIT: cfg_dim_limit = data[7:0];
         REG_BOUNDARY:  cfg_boundary  = data[7:0];
         REG_TIMER_DIV: cfg_timer_div = data[7:0];
         default: ;
      endcase
   endtask

   // sample at the falling edge so queue activity at the rising edge is settled
   task automatic wait_drained();
      do @(negedge clock);
      while (request_words.size() != 0 || req_valid || pending_outputs.size() != 0);
   endtask

   function automatic req_word_type make_request(logic [1:0] f, logic [4:0] idx,
                                                 logic [7:0] pix, logic [7:0] lvl,
                                                 logic clk_on);
      req_word_type w;
      w.func              = f;
      w.buffer_index      = idx;
      w.pixel_byte        = pix;
      w.light_level       = lvl;
      w.clock_mode_active = clk_on;
      return w;
   endfunction

   function automatic req_word_type random_request();
      req_word_type w;
      int           pick;
      w    = 24'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
         w.func = FUNC_TICK;
      end else if (pick < 80) begin
         w.func = FUNC_LIGHT;
         // favor the edges of the dimming curve
         case ($urandom_range(0, 5))
            0: w.light_level = cfg_boundary;
            1: w.light_level = cfg_boundary + 8'd1;
            2: w.light_level = cfg_dim_limit;
            3: w.light_level = cfg_dim_limit + 8'd1;
            4: w.light_level = 8'($urandom_range(0, 40));
            default: ;
         endcase
      end else if (pick < 96) begin
         w.func         = FUNC_WRITE;
         w.buffer_index = (pick < 94) ? 5'($urandom_range(0, BUFFER_BYTES - 1))
                                      : 5'($urandom_range(BUFFER_BYTES, 31));
      end else begin
         w.func = FUNC_NONE;
      end
      return w;
   endfunction

   task automatic run_phase(logic layout, logic drv, logic [7:0] frame, logic [7:0] dstep,
                            logic [7:0] dlimit, logic [7:0] bound, logic [7:0] tdiv);
      repeat (4) @(posedge clock);
      write_register(REG_LAYOUT, {7'd0, layout});
      write_register(REG_DRIVER, {7'd0, drv});
      write_register(REG_FRAME, frame);
      write_register(REG_DIM_STEP, dstep);
      write_register(REG_DIM_LIMIT, dlimit);
      write_register(REG_BOUNDARY, bound);
      write_register(REG_TIMER_DIV, tdiv);
      @(negedge clock);
      repeat (PHASE_WORDS) request_words.push_back(random_request());
      phases++;
      wait_drained();
   endtask

   // tick until the countdown is spent and the scan has reached min_step
   task automatic settle_scan(logic [3:0] min_step);
      req_word_type w;
      int           guard;
      guard = 0;
      while (!(dim_count == 0 && step_idx >= min_step) && guard < 600) begin
         w      = 24'($urandom);
         w.func = FUNC_TICK;
         request_words.push_back(w);
         wait_drained();
         guard++;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // buffer extremes, ignored writes, dimming curve corners, unknown func
      request_words.push_back(make_request(FUNC_WRITE, 5'd0, 8'hff, 8'h00, 1'b0));
      request_words.push_back(make_request(FUNC_WRITE, 5'd23, 8'h00, 8'hff, 1'b1));
      request_words.push_back(make_request(FUNC_WRITE, 5'd7, 8'h81, 8'h5a, 1'b0));
      request_words.push_back(make_request(FUNC_WRITE, 5'd15, 8'h3c, 8'ha5, 1'b1));
      request_words.push_back(make_request(FUNC_WRITE, 5'd16, 8'hc3, 8'h00, 1'b0));
      request_words.push_back(make_request(FUNC_WRITE, 5'd24, 8'h55, 8'h00, 1'b1));
      request_words.push_back(make_request(FUNC_WRITE, 5'd31, 8'hff, 8'hff, 1'b1));
      request_words.push_back(make_request(FUNC_NONE, 5'd31, 8'hff, 8'hff, 1'b1));
      request_words.push_back(make_request(FUNC_LIGHT, 5'd31, 8'hff, 8'hff, 1'b0));
      request_words.push_back(make_request(FUNC_LIGHT, 5'd0, 8'h00, 8'd0, 1'b1));
      request_words.push_back(make_request(FUNC_LIGHT, 5'd0, 8'h00, 8'd3, 1'b1));
      request_words.push_back(make_request(FUNC_LIGHT, 5'd0, 8'h00, 8'd4, 1'b1));
      request_words.push_back(make_request(FUNC_LIGHT, 5'd0, 8'h00, 8'd25, 1'b1));
      request_words.push_back(make_request(FUNC_LIGHT, 5'd0, 8'h00, 8'd26, 1'b1));
      request_words.push_back(make_request(FUNC_LIGHT, 5'd0, 8'h00, 8'd255, 1'b1));
      request_words.push_back(make_request(FUNC_LIGHT, 5'd0, 8'h00, 8'd10, 1'b1));
      repeat (8) request_words.push_back(make_request(FUNC_TICK, 5'd31, 8'hff, 8'hff, 1'b1));
      phases++;
      wait_drained();

      run_phase(1'b0, 1'b1, 8'd16, 8'd1, 8'd255, 8'd0, 8'd0);
      run_phase(1'b0, 1'b0, 8'd255, 8'd3, 8'd6, 8'd2, 8'd5);
      run_phase(1'b1, 1'b0, 8'd16, 8'd255, 8'd1, 8'd254, 8'd255);
      run_phase(1'b1, 1'b1, 8'd40, 8'd2, 8'd20, 8'd5, 8'd1);
      // park mid row line so the column scan meets leftover steps
      settle_scan(4'($urandom_range(4, 12)));
      // frame delay below the last step: countdown reload wraps
      run_phase(1'b0, 1'b0, 8'd2, 8'd8, 8'd30, 8'd0, 8'd2);
      settle_scan(4'd0);
      run_phase(1'b1, 1'b1, 8'd7, 8'd1, 8'd1, 8'd0, 8'd128);
      settle_scan(4'd0);
      repeat (2)
         run_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   8'($urandom_range(16, 48)), 8'($urandom_range(1, 16)),
                   8'($urandom_range(1, 60)), 8'($urandom_range(0, 10)),
                   8'($urandom_range(0, 255)));

      repeat (10) @(posedge clock);
      $display("Covered %0d ticks, %0d light samples, %0d writes, %0d unknown over %0d settings.",
               func_count[FUNC_TICK], func_count[FUNC_LIGHT], func_count[FUNC_WRITE],
               func_count[FUNC_NONE], phases);
      $display("Checked %0d output words: %0d bytes, %0d latches, %0d timer pulses, %0d dark.",
               words_checked, bytes_seen, latches_seen, pulses_seen, dark_seen);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Timed out with %0d output words still expected.", pending_outputs.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/lmsd_pkg.sv
rtl/core/lmsd_ram.sv
rtl/core/led_matrix_scan_with_dimming.sv
tb/tb_top.sv
